[hdl/rv32lsu_pkg.sv]
// Package for the RV32I load/store unit: memory size, request codes,
// error codes and the byte-lane mask function. No dependencies.
package rv32lsu_pkg;

	localparam int MEM_WORDS = 4096;
	localparam int IDX_W = $clog2(MEM_WORDS);

	localparam logic [2:0] REQ_LW = 3'd0;
	localparam logic [2:0] REQ_LB = 3'd1;
	localparam logic [2:0] REQ_LBU = 3'd2;
	localparam logic [2:0] REQ_SW = 3'd3;
	localparam logic [2:0] REQ_SB = 3'd4;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_MISALIGNED = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;

	function automatic logic [31:0] lane_keep(input logic [1:0] lane);
		logic [31:0] m;
		unique case (lane)
			2'd0: m = 32'hFFFF_FF00;
			2'd1: m = 32'hFFFF_00FF;
			2'd2: m = 32'hFF00_FFFF;
			default: m = 32'h00FF_FFFF;
		endcase
		return m;
	endfunction

endpackage

[hdl/rv32_load_store_unit.sv]
// RV32I load/store unit over a word-organized data memory.
// Depends on rv32lsu_pkg and rv32lsu_ram.
// A request and its memory read register into stage 1, the response as stage 1 advances.
// Throughput: one request per cycle unless the response stalls; a byte store reads its
// word on acceptance and writes it back as stage 1 advances, with the last write forwarded.
// Reset clears the pipeline valids only; memory content is undefined until written.
module rv32_load_store_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic [31:0]        base_address,
	input  logic signed [11:0] offset,
	input  logic signed [31:0] write_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] read_data,
	output logic [1:0]         error_code
);
	import rv32lsu_pkg::*;

	logic             accept;
	logic [31:0]      ea;
	logic             word_op;
	logic [1:0]       in_err;
	logic [IDX_W-1:0] in_idx;

	logic             s1_vld;
	logic [2:0]       req_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [1:0]       lane_s1;
	logic [31:0]      wdata_s1;
	logic [1:0]       err_s1;
	logic             fwd_hit_s1;
	logic [31:0]      fwd_data_s1;

	logic             s1_adv;
	logic [31:0]      ram_rdata;
	logic [31:0]      word;
	logic [7:0]       byte_v;
	logic [31:0]      rd_value;
	logic             wr_req;
	logic [31:0]      wr_word;
	logic             wr_en;

	logic             rsp_valid_q;
	logic [31:0]      read_data_q;
	logic [1:0]       error_code_q;

	assign s1_adv = s1_vld && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_vld && !s1_adv;
	assign accept = req_valid && !req_stall;

	assign ea = base_address + {{20{offset[11]}}, offset};
	assign word_op = (req_type == REQ_LW) || (req_type == REQ_SW);
	assign in_idx = ea[IDX_W+1:2];

	always_comb begin
		in_err = ERR_OK;
		if (req_type <= REQ_SB) begin
			if (word_op && (ea[1:0] != 2'b00)) begin
				in_err = ERR_MISALIGNED;
			end else if (ea[31:2] >= 30'(MEM_WORDS)) begin
				in_err = ERR_RANGE;
			end
		end
	end

	rv32lsu_ram #(
		.WIDTH(32),
		.DEPTH(MEM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_s1),
		.wdata(wr_word),
		.re   (accept),
		.raddr(in_idx),
		.rdata(ram_rdata)
	);

	assign word = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign byte_v = 8'(word >> {lane_s1, 3'b000});

	always_comb begin
		rd_value = 32'd0;
		wr_req = 1'b0;
		wr_word = wdata_s1;
		if (err_s1 == ERR_OK) begin
			case (req_s1)
				REQ_LW: rd_value = word;
				REQ_LB: rd_value = {{24{byte_v[7]}}, byte_v};
				REQ_LBU: rd_value = {24'd0, byte_v};
				REQ_SW: wr_req = 1'b1;
				REQ_SB: begin
					wr_req = 1'b1;
					wr_word = (word & lane_keep(lane_s1))
						| ((wdata_s1 & BYTE_MASK) << {lane_s1, 3'b000});
				end
				default: rd_value = 32'd0;
			endcase
		end
	end

	assign wr_en = s1_adv && wr_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld <= 1'b1;
			end else if (s1_adv) begin
				s1_vld <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			idx_s1 <= in_idx;
			lane_s1 <= ea[1:0];
			wdata_s1 <= write_data;
			err_s1 <= in_err;
			fwd_hit_s1 <= wr_en && (idx_s1 == in_idx);
			fwd_data_s1 <= wr_word;
		end
		if (s1_adv) begin
			read_data_q <= rd_value;
			error_code_q <= err_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign error_code = error_code_q;

endmodule

[hdl/rv32lsu_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read and a write to the same address in one cycle return old data.
module rv32lsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/rv32lsu_checker.sv]
// Port-level checks for the RV32I load/store unit and the bind that attaches them.
// Depends on rv32lsu_pkg and the rv32_load_store_unit port list.
module rv32lsu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic [2:0]         req_type,
	input logic [31:0]        base_address,
	input logic signed [11:0] offset,
	input logic signed [31:0] write_data,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [31:0] read_data,
	input logic [1:0]         error_code
);
	import rv32lsu_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(error_code))
		else $error("Stalled response changed.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (error_code != ERR_OK) |-> read_data == 32'sd0)
		else $error("Refused request returned nonzero data.");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (error_code == ERR_OK) || (error_code == ERR_MISALIGNED)
			|| (error_code == ERR_RANGE))
		else $error("Unknown error code.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("Request stalled while the response side was free.");

endmodule

bind rv32_load_store_unit rv32lsu_checker u_rv32lsu_checker (.*);
